[src/lxl_pkg.sv]
// Shared types, coefficients and log table generator for the lux to log illuminance core.
`timescale 1ns / 1ps
package lxl_pkg;

    typedef struct packed {
        logic valid;
        logic corr;
        logic sat;
        logic zero;
    } lxl_ctl_t;

    localparam int LUM_W = 34;
    localparam int X8_W  = 24;
    localparam int T_W   = 36;
    localparam int P_W   = T_W + X8_W + 1;

    localparam logic [23:0]          COEF_A64 = 24'd11092950;
    localparam logic signed [T_W-1:0] COEF_B56 = -36'sd676793746;
    localparam logic signed [T_W-1:0] COEF_C40 = 36'sd89597004;
    localparam logic signed [T_W-1:0] COEF_D24 = 36'sd16815804;
    localparam logic signed [29:0]   LOG10_2_Q16 = 30'sd197283018;

    localparam logic [15:0] OUT_MAX = 16'hFFFF;

    // log2(1 + i/2^ltb) in Q30 by repeated squaring, truncated
    function automatic logic [30:0] log2_entry(input int i, input int ltb);
        logic [63:0] m;
        logic [30:0] y;
        m = (64'd1 << 30) + (64'(i) << (30 - ltb));
        y = '0;
        if (i >= (1 << ltb))
        begin
            y = 31'd1 << 30;
        end
        else
        begin
            for (int k = 0; k < 30; k++)
            begin
                m = (m * m) >> 30;
                y = {y[29:0], 1'b0};
                if (m >= (64'd1 << 31))
                begin
                    m = m >> 1;
                    y[0] = 1'b1;
                end
            end
        end
        return y;
    endfunction

endpackage

[src/lux_counts_to_log_illuminance_core.sv]
// Top level: converts raw light counts to clipped 10000*log10(lux)+1.
`timescale 1ns / 1ps
// Usage:
//   Request channel: drive raw_counts and pulse start. busy stays low, so a
//   request is taken at every edge where start is high, one per cycle.
//   Result channel: done is high for one cycle with log_illuminance and
//   clipped valid in that cycle. Results come out in request order.
//   Pipeline: the count times resolution product is registered first,
//   then the classification and four-step Horner correction run in
//   stages a to e, then the normalization, table interpolation, scaling
//   and clipping run in stages f to i and the output register.
//   Throughput: one result per cycle, sustained, set by the fully
//   pipelined multiplier chain.
//   Configuration: write lux_per_count on cfg_data with cfg_valid;
//   cfg_ready is always high. Write only while no request is in flight.
//   Reset: clears all pipeline valid bits and loads lux_per_count with
//   70465. The receiver cannot stall; each result is shown exactly once.
module lux_counts_to_log_illuminance_core #(
    parameter int RES_FRAC_BITS  = 16,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] raw_counts,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [17:0] cfg_data,
    output logic        done,
    output logic [15:0] log_illuminance,
    output logic        clipped
);
    import lxl_pkg::*;

    logic [17:0]      lpc_reg;
    logic             lum_valid_reg;
    logic [LUM_W-1:0] lum_reg;
    lxl_ctl_t         poly_ctl;
    logic [LUM_W-1:0] poly_val;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpc_reg       <= 18'd70465;
            lum_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                lpc_reg <= cfg_data;
            lum_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        lum_reg <= raw_counts * lpc_reg;
    end

    lxl_poly #(
        .RES_FRAC_BITS(RES_FRAC_BITS)
    ) u_poly (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(lum_valid_reg),
        .lum     (lum_reg),
        .out_ctl (poly_ctl),
        .out_val (poly_val)
    );

    lxl_log #(
        .RES_FRAC_BITS (RES_FRAC_BITS),
        .LOG_TABLE_BITS(LOG_TABLE_BITS)
    ) u_log (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ctl         (poly_ctl),
        .in_val         (poly_val),
        .done           (done),
        .log_illuminance(log_illuminance),
        .clipped        (clipped)
    );

endmodule

[src/lxl_poly.sv]
// Classification and pipelined quartic correction of the lux product.
`timescale 1ns / 1ps
module lxl_poly #(
    parameter int RES_FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [lxl_pkg::LUM_W-1:0]  lum,
    output lxl_pkg::lxl_ctl_t          out_ctl,
    output logic [lxl_pkg::LUM_W-1:0]  out_val
);
    import lxl_pkg::*;

    localparam logic [40:0] THR_LO = 41'd1000 << RES_FRAC_BITS;
    localparam logic [40:0] THR_HI = 41'd65536 << RES_FRAC_BITS;

    lxl_ctl_t a_ctl_reg, b_ctl_reg, c_ctl_reg, d_ctl_reg, e_ctl_reg;
    lxl_ctl_t a_ctl_next;
    logic [LUM_W-1:0] a_lum_reg, b_lum_reg, c_lum_reg, d_lum_reg, e_val_reg;
    logic [X8_W-1:0]  a_x8_reg, b_x8_reg, c_x8_reg;
    logic [X8_W-1:0]  x8;
    logic [47:0]      a_p_reg;
    logic signed [P_W-1:0] b_p_reg, c_p_reg, d_p_reg;
    logic signed [T_W-1:0] t1, t2, t3;
    logic signed [P_W-25:0] lux;
    logic [40:0] lum_ext;
    logic [LUM_W-1:0] e_val_next;

    assign lum_ext = {7'd0, lum};
    assign x8 = X8_W'(lum >> (RES_FRAC_BITS - 8));

    always_comb
    begin
        a_ctl_next       = '0;
        a_ctl_next.valid = in_valid;
        a_ctl_next.sat   = (lum_ext >= THR_HI);
        a_ctl_next.corr  = (lum_ext > THR_LO) && (lum_ext < THR_HI);
    end

    assign t1 = $signed({{(T_W-32){1'b0}}, a_p_reg[47:16]}) + COEF_B56;
    assign t2 = T_W'(b_p_reg >>> 24) + COEF_C40;
    assign t3 = T_W'(c_p_reg >>> 24) + COEF_D24;
    assign lux = (P_W-24)'(d_p_reg >>> 24);

    always_comb
    begin
        if (!d_ctl_reg.corr)
            e_val_next = d_lum_reg;
        else if (lux > 0)
            e_val_next = lux[LUM_W-1:0];
        else
            e_val_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
            c_ctl_reg <= '0;
            d_ctl_reg <= '0;
            e_ctl_reg <= '0;
        end
        else
        begin
            a_ctl_reg <= a_ctl_next;
            b_ctl_reg <= a_ctl_reg;
            c_ctl_reg <= b_ctl_reg;
            d_ctl_reg <= c_ctl_reg;
            e_ctl_reg <= d_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_lum_reg <= lum;
        a_x8_reg  <= x8;
        a_p_reg   <= COEF_A64 * x8;
        b_lum_reg <= a_lum_reg;
        b_x8_reg  <= a_x8_reg;
        b_p_reg   <= t1 * $signed({1'b0, a_x8_reg});
        c_lum_reg <= b_lum_reg;
        c_x8_reg  <= b_x8_reg;
        c_p_reg   <= t2 * $signed({1'b0, b_x8_reg});
        d_lum_reg <= c_lum_reg;
        d_p_reg   <= t3 * $signed({1'b0, c_x8_reg});
        e_val_reg <= e_val_next;
    end

    assign out_ctl = e_ctl_reg;
    assign out_val = e_val_reg;

endmodule

[src/lxl_log.sv]
// Pipelined log2 by normalization and table interpolation, scaled to 10000*log10 and clipped.
`timescale 1ns / 1ps
module lxl_log #(
    parameter int RES_FRAC_BITS  = 16,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lxl_pkg::lxl_ctl_t          in_ctl,
    input  logic [lxl_pkg::LUM_W-1:0]  in_val,
    output logic                       done,
    output logic [15:0]                log_illuminance,
    output logic                       clipped
);
    import lxl_pkg::*;

    localparam int TAB_N = (1 << LOG_TABLE_BITS) + 1;
    localparam int REM_W = 30 - LOG_TABLE_BITS;

    logic [30:0] tab [TAB_N];

    genvar g;
    generate
        for (g = 0; g < TAB_N; g++)
        begin : g_tab
            localparam logic [30:0] ENTRY = log2_entry(g, LOG_TABLE_BITS);
            assign tab[g] = ENTRY;
        end
    endgenerate

    lxl_ctl_t f_ctl_reg, g_ctl_reg, h_ctl_reg, i_ctl_reg;
    lxl_ctl_t f_ctl_next;
    logic [5:0] e_det;
    logic [5:0] f_e_reg;
    logic [LUM_W-1:0] f_val_reg;
    logic [LUM_W-1:0] norm;
    logic [29:0] frac;
    logic [LOG_TABLE_BITS-1:0] idx;
    logic [LOG_TABLE_BITS:0] idx_hi;
    logic signed [6:0] exp_next;
    logic [30:0] g_lo_reg, g_diff_reg, h_lo_reg, h_interp_reg;
    logic [REM_W-1:0] g_rem_reg;
    logic signed [6:0] g_exp_reg, h_exp_reg;
    logic [30+REM_W:0] interp_prod;
    logic signed [37:0] log2_sum;
    logic signed [31:0] l24;
    logic signed [61:0] i_prod_reg;
    logic signed [62:0] s_val;
    logic done_reg, done_next;
    logic [15:0] log_reg, log_next;
    logic clip_reg, clip_next;

    // highest set bit wins
    always_comb
    begin
        e_det = '0;
        for (int b = 0; b < LUM_W; b++)
        begin
            if (in_val[b])
                e_det = 6'(b);
        end
    end

    always_comb
    begin
        f_ctl_next      = in_ctl;
        f_ctl_next.zero = (in_val == '0);
    end

    assign norm     = f_val_reg << (6'(LUM_W - 1) - f_e_reg);
    assign frac     = norm[LUM_W-2:LUM_W-31];
    assign idx      = frac[29 -: LOG_TABLE_BITS];
    assign idx_hi   = {1'b0, idx} + 1'b1;
    assign exp_next = $signed({1'b0, f_e_reg})
                    - (f_ctl_reg.corr ? 7'sd8 : 7'(RES_FRAC_BITS));

    assign interp_prod = g_diff_reg * g_rem_reg;

    assign log2_sum = ($signed({{31{h_exp_reg[6]}}, h_exp_reg}) <<< 30)
                    + $signed({7'd0, h_lo_reg}) + $signed({7'd0, h_interp_reg});
    assign l24 = 32'(log2_sum >>> 6);

    assign s_val = $signed({i_prod_reg[61], i_prod_reg}) + (63'sd1 <<< 40);

    always_comb
    begin
        done_next = i_ctl_reg.valid;
        log_next  = '0;
        clip_next = 1'b0;
        priority if (i_ctl_reg.sat)
        begin
            log_next  = OUT_MAX;
            clip_next = 1'b1;
        end
        else if (i_ctl_reg.zero || s_val < 0)
        begin
            clip_next = 1'b1;
        end
        else if (s_val[62:40] > 23'd65535)
        begin
            log_next  = OUT_MAX;
            clip_next = 1'b1;
        end
        else
        begin
            log_next = s_val[55:40];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_ctl_reg <= '0;
            g_ctl_reg <= '0;
            h_ctl_reg <= '0;
            i_ctl_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            f_ctl_reg <= f_ctl_next;
            g_ctl_reg <= f_ctl_reg;
            h_ctl_reg <= g_ctl_reg;
            i_ctl_reg <= h_ctl_reg;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_e_reg      <= e_det;
        f_val_reg    <= in_val;
        g_lo_reg     <= tab[idx];
        g_diff_reg   <= tab[idx_hi] - tab[idx];
        g_rem_reg    <= frac[REM_W-1:0];
        g_exp_reg    <= exp_next;
        h_lo_reg     <= g_lo_reg;
        h_exp_reg    <= g_exp_reg;
        h_interp_reg <= 31'(interp_prod >> REM_W);
        i_prod_reg   <= l24 * LOG10_2_Q16;
        log_reg      <= log_next;
        clip_reg     <= clip_next;
    end

    assign done            = done_reg;
    assign log_illuminance = log_reg;
    assign clipped         = clip_reg;

endmodule

[test/lux_counts_to_log_illuminance_core_test.sv]
// Self-checking testbench for the lux count to log illuminance core.
`timescale 1ns / 1ps
module lux_counts_to_log_illuminance_core_test;
    import lxl_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int TAB_BITS = 8;
    localparam int LATENCY = 11;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [17:0] LPC_RESET = 18'd70465;
    localparam logic [17:0] LPC_MAX = 18'h3FFFF;

    typedef struct {
        logic [15:0] log_lux;
        logic        clip;
    } illum_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] raw_counts;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [17:0] cfg_data;
    logic        done;
    logic [15:0] log_illuminance;
    logic        clipped;

    illum_t      illum_queue[$];
    logic [17:0] model_lpc;
    longint      log2_tab[0:(1 << TAB_BITS)];
    int          send_gap_pct;
    int          fail_count;
    int          idle_cycles;

    lux_counts_to_log_illuminance_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .raw_counts(raw_counts),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .done(done),
        .log_illuminance(log_illuminance),
        .clipped(clipped)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic void build_log2_tab();
        longint unsigned m;
        longint unsigned y;
        for (int i = 0; i < (1 << TAB_BITS); i++)
        begin
            m = (64'd1 << 30) + (64'(i) << (30 - TAB_BITS));
            y = 0;
            for (int k = 0; k < 30; k++)
            begin
                m = (m * m) >> 30;
                y = y << 1;
                if (m >= (64'd1 << 31))
                begin
                    m = m >> 1;
                    y = y | 1;
                end
            end
            log2_tab[i] = longint'(y);
        end
        log2_tab[1 << TAB_BITS] = 64'sd1 << 30;
    endfunction

    // log2(v / 2^fb) in Q30, then scaled to 10000*log10 + 1 with clipping
    function automatic illum_t log_scale(longint unsigned v, int fb);
        illum_t r;
        int e;
        longint unsigned norm, frac, rem;
        int idx;
        longint lo, hi, lg, l24, s, t;
        if (v == 0)
        begin
            r.log_lux = 16'd0;
            r.clip = 1'b1;
            return r;
        end
        e = 0;
        while (e < 63 && (v >> (e + 1)) != 0)
            e++;
        norm = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        frac = norm - (64'd1 << 30);
        idx = int'(frac >> (30 - TAB_BITS)) & ((1 << TAB_BITS) - 1);
        rem = frac & ((64'd1 << (30 - TAB_BITS)) - 1);
        lo = log2_tab[idx];
        hi = log2_tab[idx + 1];
        lg = (longint'(e) - fb) * (64'sd1 << 30) + lo
            + floor_shift((hi - lo) * longint'(rem), 30 - TAB_BITS);
        l24 = floor_shift(lg, 6);
        s = l24 * 64'sd197283018 + (64'sd1 << 40);
        if (s < 0)
        begin
            r.log_lux = 16'd0;
            r.clip = 1'b1;
            return r;
        end
        t = s >>> 40;
        if (t > 65535)
        begin
            r.log_lux = 16'hFFFF;
            r.clip = 1'b1;
        end
        else
        begin
            r.log_lux = t[15:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    function automatic illum_t predict_illuminance(logic [15:0] counts);
        illum_t r;
        longint unsigned lum;
        longint x8, acc;
        lum = longint'(counts) * longint'(model_lpc);
        if (lum <= (64'd1000 << FRAC_BITS))
            return log_scale(lum, FRAC_BITS);
        if (lum >= (64'd65536 << FRAC_BITS))
        begin
            r.log_lux = 16'hFFFF;
            r.clip = 1'b1;
            return r;
        end
        // quartic correction by Horner steps
        x8 = longint'(lum >> (FRAC_BITS - 8));
        acc = floor_shift(64'sd11092950 * x8, 16) - 64'sd676793746;
        acc = floor_shift(acc * x8, 24) + 64'sd89597004;
        acc = floor_shift(acc * x8, 24) + 64'sd16815804;
        acc = floor_shift(acc * x8, 24);
        return log_scale((acc > 0) ? longint'(acc) : 0, 8);
    endfunction

    // hold start high across back-to-back requests; drop it only while idling
    task automatic send_counts(logic [15:0] counts);
        while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        raw_counts <= counts;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        illum_queue.push_back(predict_illuminance(counts));
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        while (illum_queue.size() != 0 && idle_cycles < WATCHDOG_LIMIT)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic write_lpc(logic [17:0] value);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model_lpc = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Lux boundaries, zero cases, saturation and bit extremes of the count.
    task automatic test_directed();
        send_counts(16'd0);
        send_counts(16'd1);
        send_counts(16'hFFFF);
        send_counts(16'h5555);
        send_counts(16'hAAAA);
        send_counts(16'd930);
        send_counts(16'd931);
        send_counts(16'd932);
        write_lpc(18'd65536);
        send_counts(16'd1000);
        send_counts(16'd1001);
        send_counts(16'd65535);
        write_lpc(18'd0);
        send_counts(16'd500);
        write_lpc(18'd1);
        send_counts(16'd1);
        send_counts(16'd2);
        send_counts(16'hFFFF);
        write_lpc(LPC_MAX);
        send_counts(16'd1);
        send_counts(16'd250);
        send_counts(16'd16383);
        send_counts(16'd16384);
        send_counts(16'hFFFF);
    endtask

    task automatic test_random_counts(int n);
        logic [15:0] c;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0: c = 16'($urandom_range(65535));
                1: c = 16'($urandom_range(2000));
                2: c = 16'(1) << $urandom_range(15);
                default: c = 16'($urandom_range(40000, 65535));
            endcase
            send_counts(c);
        end
    endtask

    task automatic test_resolution_sweep();
        write_lpc(18'($urandom_range(200, 300)));
        test_random_counts(60);
        write_lpc(18'($urandom));
        test_random_counts(60);
        write_lpc(18'($urandom_range(60000, 80000)));
        test_random_counts(60);
    endtask

    always @(posedge clk)
    begin
        illum_t want;
        if (rst_n && done)
        begin
            if (illum_queue.size() == 0)
            begin
                $error("unexpected result: log_illuminance=%0d clipped=%0b",
                    log_illuminance, clipped);
                fail_count++;
            end
            else
            begin
                want = illum_queue.pop_front();
                if (log_illuminance !== want.log_lux)
                begin
                    $error("log_illuminance: expected %0d, got %0d",
                        want.log_lux, log_illuminance);
                    fail_count++;
                end
                if (clipped !== want.clip)
                begin
                    $error("clipped: expected %0b, got %0b", want.clip, clipped);
                    fail_count++;
                end
            end
        end
    end

    // count cycles with no accepted request, result or configuration write
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** lux_counts_to_log_illuminance_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        raw_counts = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        fail_count = 0;
        idle_cycles = 0;
        send_gap_pct = 0;
        model_lpc = LPC_RESET;
        build_log2_tab();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_gap_pct = 22;
        test_directed();
        test_resolution_sweep();
        send_gap_pct = 65;
        write_lpc(LPC_RESET);
        test_random_counts(150);
        send_gap_pct = 0;
        write_lpc(18'($urandom_range(1, 4000)));
        test_random_counts(80);
        write_lpc(18'($urandom));
        test_random_counts(160);
        write_lpc(18'($urandom_range(0, 100)));
        test_random_counts(60);

        drain_pipeline();
        if (fail_count == 0 && illum_queue.size() == 0)
            $display("** lux_counts_to_log_illuminance_core: PASSED **");
        else
            $display("** lux_counts_to_log_illuminance_core: FAILED **");
        $finish;
    end
endmodule

[files.f]
src/lxl_pkg.sv
src/lxl_poly.sv
src/lxl_log.sv
src/lux_counts_to_log_illuminance_core.sv
test/lux_counts_to_log_illuminance_core_test.sv
